FILE: hdl/bwmg_pkg.sv
// Shared constants, register codes and stage interface types for the Butterworth mask gain core.
`timescale 1ns / 1ps

package bwmg_pkg;

    // Limits on the spectrum size and the filter order.
    localparam int MAX_DIM   = 4096;
    localparam int MAX_ORDER = 8;

    // Field and datapath widths.
    localparam int COORD_W = 12;   // row and column coordinates
    localparam int DIM_W   = 13;   // spectrum height and width
    localparam int RAD_W   = 16;   // cutoff radius, Q12.4
    localparam int ORD_W   = 4;    // filter order
    localparam int WID_W   = 16;   // notch width, Q8.8
    localparam int ADDR_W  = 5;    // APB byte address
    localparam int APB_W   = 32;   // APB data
    localparam int SQ_W    = 24;   // square of one offset
    localparam int D2_W    = 25;   // squared distance
    localparam int RSQ_W   = 32;   // squared radius or squared width
    localparam int AD_W    = 33;   // |d^2 * 256 - R^2|
    localparam int NUM_W   = 57;   // d^2 * W^2
    localparam int NN_W    = 73;   // ratio dividend
    localparam int DD_W    = 66;   // ratio divisor
    localparam int NH_W    = 41;   // dividend bits above the quotient bits
    localparam int T_W     = 32;   // ratio, Q16.16
    localparam int P_W     = 32;   // power, Q16.16
    localparam int DEN_W   = 33;   // 1.0 + power
    localparam int G_W     = 16;   // gain, Q1.15

    // Filter modes.
    localparam logic MODE_LOWPASS = 1'b0;
    localparam logic MODE_BANDREJ = 1'b1;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_CUTOFF = 3'd0;
    localparam logic [2:0] REG_ORDER  = 3'd1;
    localparam logic [2:0] REG_NOTCH  = 3'd2;
    localparam logic [2:0] REG_MODE   = 3'd3;
    localparam logic [2:0] REG_ROWS   = 3'd4;
    localparam logic [2:0] REG_COLS   = 3'd5;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [RSQ_W-1:0]   cutoff_sq;
        logic [RSQ_W-1:0]   notch_sq;
        logic [COORD_W-1:0] row_centre;
        logic [COORD_W-1:0] col_centre;
        logic               mode;
        logic [ORD_W-1:0]   order_n;
    } cfg_t;

    // Ratio stage result.
    typedef struct packed {
        logic           valid;
        logic           sat;
        logic [T_W-1:0] t;
    } ratio_t;

    // Power stage result.
    typedef struct packed {
        logic           valid;
        logic           sat;
        logic [P_W-1:0] p;
    } power_t;

    // Final gain beat.
    typedef struct packed {
        logic           valid;
        logic [G_W-1:0] gain;
    } result_t;

endpackage

FILE: hdl/bwmg_cfg.sv
// APB register file holding the mask configuration and its derived terms.
`timescale 1ns / 1ps

module bwmg_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bwmg_pkg::ADDR_W-1:0] paddr,
    input  logic [bwmg_pkg::APB_W-1:0]  pwdata,
    output logic [bwmg_pkg::APB_W-1:0]  prdata,
    output logic                      pready,
    output bwmg_pkg::cfg_t            cfg
);
    import bwmg_pkg::*;

    logic [RAD_W-1:0]  cutoff_reg;
    logic [ORD_W-1:0]  order_reg;
    logic [WID_W-1:0]  notch_reg;
    logic              mode_reg;
    logic [DIM_W-1:0]  rows_reg;
    logic [DIM_W-1:0]  cols_reg;
    logic [RSQ_W-1:0]  cutoff_sq_reg;
    logic [RSQ_W-1:0]  notch_sq_reg;
    logic              wr_en;
    logic [DIM_W-1:0]  rows_clamp;
    logic [DIM_W-1:0]  cols_clamp;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= RAD_W'(32);
            order_reg  <= ORD_W'(4);
            notch_reg  <= WID_W'(768);
            mode_reg   <= MODE_LOWPASS;
            rows_reg   <= DIM_W'(512);
            cols_reg   <= DIM_W'(512);
        end
        else if (wr_en)
        begin
            unique case (paddr[ADDR_W-1:2])
                REG_CUTOFF: cutoff_reg <= pwdata[RAD_W-1:0];
                REG_ORDER:  order_reg  <= pwdata[ORD_W-1:0];
                REG_NOTCH:  notch_reg  <= pwdata[WID_W-1:0];
                REG_MODE:   mode_reg   <= pwdata[0];
                REG_ROWS:   rows_reg   <= pwdata[DIM_W-1:0];
                REG_COLS:   cols_reg   <= pwdata[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        unique case (paddr[ADDR_W-1:2])
            REG_CUTOFF: prdata = APB_W'(cutoff_reg);
            REG_ORDER:  prdata = APB_W'(order_reg);
            REG_NOTCH:  prdata = APB_W'(notch_reg);
            REG_MODE:   prdata = APB_W'(mode_reg);
            REG_ROWS:   prdata = APB_W'(rows_reg);
            REG_COLS:   prdata = APB_W'(cols_reg);
            default:    prdata = '0;
        endcase
    end

    // Squares of radius and width; they are first read several stages into the pipe.
    always_ff @(posedge clk)
    begin
        cutoff_sq_reg <= RSQ_W'(cutoff_reg * cutoff_reg);
        notch_sq_reg  <= RSQ_W'(notch_reg * notch_reg);
    end

    // Centres are needed in the first stage, so they stay combinational.
    assign rows_clamp = (rows_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rows_reg;
    assign cols_clamp = (cols_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cols_reg;

    assign cfg.cutoff_sq  = cutoff_sq_reg;
    assign cfg.notch_sq   = notch_sq_reg;
    assign cfg.row_centre = rows_clamp[DIM_W-1:1];
    assign cfg.col_centre = cols_clamp[DIM_W-1:1];
    assign cfg.mode       = mode_reg;
    assign cfg.order_n    = (order_reg > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : order_reg;

endmodule

FILE: hdl/bwmg_ratio.sv
// Distance, ratio terms and a pipelined long division that yield (d/R)^2 style ratio in Q16.16.
`timescale 1ns / 1ps

module bwmg_ratio (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [bwmg_pkg::COORD_W-1:0] row_index,
    input  logic [bwmg_pkg::COORD_W-1:0] col_index,
    input  bwmg_pkg::cfg_t              cfg,
    output bwmg_pkg::ratio_t            res
);
    import bwmg_pkg::*;

    logic [5:1]          vld_reg;
    logic [COORD_W:0]    dy;
    logic [COORD_W:0]    dx;
    logic [COORD_W-1:0]  ady_reg;
    logic [COORD_W-1:0]  adx_reg;
    logic [SQ_W-1:0]     dy2_reg;
    logic [SQ_W-1:0]     dx2_reg;
    logic [D2_W-1:0]     d2_reg;
    logic [D2_W-1:0]     d2b_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [AD_W-1:0]     ad_reg;
    logic [AD_W-1:0]     d2q8;
    logic [AD_W-1:0]     r2x;
    logic [NN_W-1:0]     nn_reg;
    logic [DD_W-1:0]     dd_reg;

    logic [DD_W-1:0]     dv_rem_reg [0:T_W];
    logic [DD_W-1:0]     dv_d_reg   [0:T_W];
    logic [T_W-1:0]      dv_nl_reg  [0:T_W];
    logic [T_W-1:0]      dv_q_reg   [0:T_W];
    logic                dv_sat_reg [0:T_W];
    logic                dv_v_reg   [0:T_W];

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[4:1], in_valid};
    end

    // Signed offsets from the centre; the first stage takes their magnitudes.
    always_comb
    begin
        dy = {1'b0, row_index} - {1'b0, cfg.row_centre};
        dx = {1'b0, col_index} - {1'b0, cfg.col_centre};
    end

    // Front stages: offsets, squares, distance, ratio terms, dividend and divisor.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ady_reg <= dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
            adx_reg <= dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
            dy2_reg <= SQ_W'(ady_reg * ady_reg);
            dx2_reg <= SQ_W'(adx_reg * adx_reg);
            d2_reg  <= D2_W'(dy2_reg) + D2_W'(dx2_reg);
            d2b_reg <= d2_reg;
            num_reg <= NUM_W'(d2_reg * cfg.notch_sq);
            ad_reg  <= (d2q8 >= r2x) ? (d2q8 - r2x) : (r2x - d2q8);
            if (cfg.mode == MODE_BANDREJ)
            begin
                nn_reg <= {num_reg, 16'h0000};
                dd_reg <= DD_W'(ad_reg * ad_reg);
            end
            else
            begin
                nn_reg <= NN_W'({d2b_reg, 24'h000000});
                dd_reg <= DD_W'(cfg.cutoff_sq);
            end
        end
    end

    assign d2q8 = {d2_reg, 8'h00};
    assign r2x  = AD_W'(cfg.cutoff_sq);

    // Division setup: a quotient of 2^32 or more, or a zero divisor, saturates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else if (en)
            dv_v_reg[0] <= vld_reg[5];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_sat_reg[0] <= DD_W'(nn_reg[NN_W-1:T_W]) >= dd_reg;
            dv_rem_reg[0] <= DD_W'(nn_reg[NN_W-1:T_W]);
            dv_nl_reg[0]  <= nn_reg[T_W-1:0];
            dv_d_reg[0]   <= dd_reg;
            dv_q_reg[0]   <= '0;
        end
    end

    // One quotient bit per stage, restoring division.
    for (genvar j = 1; j <= T_W; j++)
    begin : g_div
        logic [DD_W:0] trial;
        logic          ge;

        always_comb
        begin
            trial = {dv_rem_reg[j-1], dv_nl_reg[j-1][T_W-1]};
            ge    = trial >= {1'b0, dv_d_reg[j-1]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[j] <= 1'b0;
            else if (en)
                dv_v_reg[j] <= dv_v_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[j] <= ge ? DD_W'(trial - {1'b0, dv_d_reg[j-1]}) : trial[DD_W-1:0];
                dv_nl_reg[j]  <= {dv_nl_reg[j-1][T_W-2:0], 1'b0};
                dv_q_reg[j]   <= {dv_q_reg[j-1][T_W-2:0], ge};
                dv_d_reg[j]   <= dv_d_reg[j-1];
                dv_sat_reg[j] <= dv_sat_reg[j-1];
            end
        end
    end

    assign res.valid = dv_v_reg[T_W];
    assign res.sat   = dv_sat_reg[T_W];
    assign res.t     = dv_q_reg[T_W];

endmodule

FILE: hdl/bwmg_power.sv
// Raises the ratio to the filter order, one truncating Q16.16 multiply per stage.
`timescale 1ns / 1ps

module bwmg_power (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [bwmg_pkg::ORD_W-1:0] order_n,
    input  bwmg_pkg::ratio_t          in_ratio,
    output bwmg_pkg::power_t          res
);
    import bwmg_pkg::*;

    logic [P_W-1:0] pw_p_reg   [1:MAX_ORDER];
    logic [T_W-1:0] pw_t_reg   [1:MAX_ORDER];
    logic           pw_sat_reg [1:MAX_ORDER];
    logic           pw_v_reg   [1:MAX_ORDER];

    for (genvar k = 1; k <= MAX_ORDER; k++)
    begin : g_step
        logic [P_W-1:0]     p_in;
        logic [T_W-1:0]     t_in;
        logic               s_in;
        logic               v_in;
        logic [P_W+T_W-1:0] prod;
        logic               act;

        // The first step starts from 1.0.
        if (k == 1)
        begin : g_first
            assign p_in = P_W'(32'h0001_0000);
            assign t_in = in_ratio.t;
            assign s_in = in_ratio.sat;
            assign v_in = in_ratio.valid;
        end
        else
        begin : g_next
            assign p_in = pw_p_reg[k-1];
            assign t_in = pw_t_reg[k-1];
            assign s_in = pw_sat_reg[k-1];
            assign v_in = pw_v_reg[k-1];
        end

        // Steps beyond the order, and steps after a saturation, pass the power through.
        always_comb
        begin
            act  = !s_in && (ORD_W'(k - 1) < order_n);
            prod = p_in * t_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                pw_v_reg[k] <= 1'b0;
            else if (en)
                pw_v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pw_p_reg[k]   <= act ? prod[P_W+15:16] : p_in;
                pw_sat_reg[k] <= s_in || (act && (prod[P_W+T_W-1:P_W+16] != '0));
                pw_t_reg[k]   <= t_in;
            end
        end
    end

    assign res.valid = pw_v_reg[MAX_ORDER];
    assign res.sat   = pw_sat_reg[MAX_ORDER];
    assign res.p     = pw_p_reg[MAX_ORDER];

endmodule

FILE: hdl/bwmg_recip.sv
// Rounded reciprocal 1/(1+p) in Q1.15 through a pipelined long division.
`timescale 1ns / 1ps

module bwmg_recip (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  bwmg_pkg::power_t  in_power,
    output bwmg_pkg::result_t res
);
    import bwmg_pkg::*;

    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] dvd;

    logic [DEN_W-1:0] rc_rem_reg [0:G_W];
    logic [DEN_W-1:0] rc_d_reg   [0:G_W];
    logic [G_W-1:0]   rc_nl_reg  [0:G_W];
    logic [G_W-1:0]   rc_q_reg   [0:G_W];
    logic             rc_sat_reg [0:G_W];
    logic             rc_v_reg   [0:G_W];

    // Divisor 1.0 + p and dividend 2^31 + divisor/2 give round half up.
    always_comb
    begin
        den = {1'b0, in_power.p} + DEN_W'(33'h0_0001_0000);
        dvd = DEN_W'(33'h0_8000_0000) + (den >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rc_v_reg[0] <= 1'b0;
        else if (en)
            rc_v_reg[0] <= in_power.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rc_rem_reg[0] <= DEN_W'(dvd[DEN_W-1:G_W]);
            rc_nl_reg[0]  <= dvd[G_W-1:0];
            rc_d_reg[0]   <= den;
            rc_q_reg[0]   <= '0;
            rc_sat_reg[0] <= in_power.sat;
        end
    end

    // One quotient bit per stage.
    for (genvar j = 1; j <= G_W; j++)
    begin : g_div
        logic [DEN_W:0] trial;
        logic           ge;

        always_comb
        begin
            trial = {rc_rem_reg[j-1], rc_nl_reg[j-1][G_W-1]};
            ge    = trial >= {1'b0, rc_d_reg[j-1]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rc_v_reg[j] <= 1'b0;
            else if (en)
                rc_v_reg[j] <= rc_v_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rc_rem_reg[j] <= ge ? DEN_W'(trial - {1'b0, rc_d_reg[j-1]}) : trial[DEN_W-1:0];
                rc_nl_reg[j]  <= {rc_nl_reg[j-1][G_W-2:0], 1'b0};
                rc_q_reg[j]   <= {rc_q_reg[j-1][G_W-2:0], ge};
                rc_d_reg[j]   <= rc_d_reg[j-1];
                rc_sat_reg[j] <= rc_sat_reg[j-1];
            end
        end
    end

    // A saturated power drives the gain to zero.
    assign res.valid = rc_v_reg[G_W];
    assign res.gain  = rc_sat_reg[G_W] ? '0 : rc_q_reg[G_W];

endmodule

FILE: hdl/butterworth_mask_gain_core.sv
// Top level of the Butterworth mask gain core: register port, datapath and output skid buffer.
//
// Usage:
// - The slave stream takes one spectrum coordinate per beat: s_tdata holds row_index in
//   bits 11:0 and col_index in bits 23:12.
// - The master stream returns one Q1.15 gain per coordinate in m_tdata, in input order.
// - The APB port sets radius, order, notch width, mode and spectrum size; write it only
//   while no coordinate is in flight. pready is always high.
// - The datapath holds 38 stages for distance and the ratio division, 8 power multiply
//   stages, 17 reciprocal stages, and the output register. The 32-bit ratio division and
//   the 16-bit reciprocal each spend one stage per quotient bit.
// - Throughput is one coordinate per cycle while the output is not stalled.
// - When the receiver stalls, the output register holds its beat and a skid register
//   catches one more; then s_tready falls and the whole pipeline holds in place.
// - Reset clears all valid bits and loads the register defaults (R 2.0, order 4,
//   width 3.0, low pass, 512 by 512).
`timescale 1ns / 1ps

module butterworth_mask_gain_core (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Coordinate stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row_index [11:0], col_index [23:12]
    // Gain stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // gain [15:0]
);
    import bwmg_pkg::*;

    cfg_t           cfg;
    ratio_t         ratio_beat;
    power_t         power_beat;
    result_t        gain_beat;
    logic           pipe_en;
    logic           out_valid_reg;
    logic [G_W-1:0] out_data_reg;
    logic           sk_valid_reg;
    logic [G_W-1:0] sk_data_reg;

    bwmg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bwmg_ratio u_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .row_index (s_tdata[COORD_W-1:0]),
        .col_index (s_tdata[2*COORD_W-1:COORD_W]),
        .cfg       (cfg),
        .res       (ratio_beat)
    );

    bwmg_power u_power (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .order_n  (cfg.order_n),
        .in_ratio (ratio_beat),
        .res      (power_beat)
    );

    bwmg_recip u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_power (power_beat),
        .res      (gain_beat)
    );

    // The pipeline moves whenever the skid register is free.
    assign pipe_en  = !sk_valid_reg;
    assign s_tready = pipe_en;

    // Output register with one skid entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sk_valid_reg  <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (sk_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                sk_valid_reg  <= 1'b0;
            end
            else
            begin
                out_valid_reg <= gain_beat.valid;
            end
        end
        else if (gain_beat.valid && pipe_en)
        begin
            sk_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_data_reg <= sk_valid_reg ? sk_data_reg : gain_beat.gain;
        end
        else if (gain_beat.valid && pipe_en)
        begin
            sk_data_reg <= gain_beat.gain;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // The skid entry is only filled behind a stalled output beat.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        sk_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a beat while the output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sk_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid entry filled without an output stall");

    // A gain never exceeds 1.0.
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata <= 16'h8000))
        else $error("gain above 1.0");

    // A held pipeline keeps its last stage.
    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(gain_beat))
        else $error("pipeline moved while held");
`endif

endmodule

FILE: sim/butterworth_mask_gain_core_tb.sv
// Self-checking testbench for the Butterworth mask gain core: APB setup, coordinate stream in, gain stream out.
`timescale 1ns / 1ps

module butterworth_mask_gain_core_tb;
    import bwmg_pkg::*;

    // Run length and timing.
    localparam int RAND_PHASES = 10;
    localparam int PHASE_BEATS = 195;
    localparam int PIPE_CYCLES = 70;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_GAP     = 18;

    // Indexes past the last register; writes there must be ignored.
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam logic [63:0] SAT_LIMIT = 64'd1 << 32;
    localparam logic [63:0] ONE_Q16   = 64'd65536;

    // One full register setting.
    typedef struct {
        logic [15:0] radius;
        logic [3:0]  order;
        logic [15:0] width;
        logic        mode;
        logic [12:0] rows;
        logic [12:0] cols;
    } mask_cfg_t;

    // One directed coordinate; the gain is checked literally when known is set.
    typedef struct {
        int          cfg_sel;
        logic [11:0] row;
        logic [11:0] col;
        logic        known;
        logic [15:0] gain;
    } probe_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // row_index [11:0], col_index [23:12]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // gain [15:0]

    mask_cfg_t   mask_cfg;
    logic [15:0] gain_queue[$];
    logic        literal_queue[$];
    logic [15:0] literal_gain[$];
    int          err_count;
    int          cycle_count;
    bit          send_idle;
    bit          recv_idle;
    bit          hold_req;
    mask_cfg_t   cfg_sets[6];
    probe_t      probes[$];

    butterworth_mask_gain_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
    end
    always #1 clk = ~clk;

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("butterworth_mask_gain_core_tb: done, errors");
            $finish;
        end
    end

    // Centre of one spectrum dimension after clamping to the largest size.
    function automatic int centre_of(logic [12:0] dim);
        int d;
        d = (dim > MAX_DIM) ? MAX_DIM : int'(dim);
        return d >> 1;
    endfunction

    // Expected Q1.15 gain at one coordinate under the current setting.
    function automatic logic [15:0] mask_gain(logic [11:0] row, logic [11:0] col);
        longint      dy;
        longint      dx;
        logic [63:0] d2;
        logic [63:0] ratio;
        logic [63:0] power;
        logic [63:0] r2;
        logic [63:0] d2q8;
        logic [63:0] diff;
        logic [63:0] num;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] den;
        int          n;
        bit          ok;
        dy = longint'(row) - centre_of(mask_cfg.rows);
        dx = longint'(col) - centre_of(mask_cfg.cols);
        d2 = dy * dy + dx * dx;
        r2 = 64'(mask_cfg.radius) * 64'(mask_cfg.radius);
        ratio = 0;
        ok = 1'b1;
        if (mask_cfg.mode == MODE_BANDREJ)
        begin
            // Band reject: ratio is (d*W / (d^2 - R^2))^2, saturating on the ring.
            d2q8 = d2 << 8;
            diff = (d2q8 >= r2) ? d2q8 - r2 : r2 - d2q8;
            num  = d2 * (64'(mask_cfg.width) * 64'(mask_cfg.width));
            if (diff == 0)
                ok = 1'b0;
            else
            begin
                hi = num / diff;
                if (hi >= (64'd1 << 47))
                    ok = 1'b0;
                else
                begin
                    lo = ((num % diff) << 16) / diff;
                    ratio = ((hi << 16) + lo) / diff;
                    if (ratio >= SAT_LIMIT)
                        ok = 1'b0;
                end
            end
        end
        else
        begin
            // Low pass: ratio is (d/R)^2; a zero radius saturates.
            if (mask_cfg.radius == 0)
                ok = 1'b0;
            else
            begin
                ratio = (d2 << 24) / r2;
                if (ratio >= SAT_LIMIT)
                    ok = 1'b0;
            end
        end
        n = (mask_cfg.order > MAX_ORDER) ? MAX_ORDER : int'(mask_cfg.order);
        power = ONE_Q16;
        for (int k = 0; k < n; k++)
        begin
            if (ok)
            begin
                power = (power * ratio) >> 16;
                if (power >= SAT_LIMIT)
                    ok = 1'b0;
            end
        end
        if (!ok)
            return 16'd0;
        den = ONE_Q16 + power;
        return 16'(((64'd1 << 31) + (den >> 1)) / den);
    endfunction

    // One APB write; the setting copy follows the masked register width.
    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_CUTOFF: mask_cfg.radius = value[15:0];
            REG_ORDER:  mask_cfg.order  = value[3:0];
            REG_NOTCH:  mask_cfg.width  = value[15:0];
            REG_MODE:   mask_cfg.mode   = value[0];
            REG_ROWS:   mask_cfg.rows   = value[12:0];
            REG_COLS:   mask_cfg.cols   = value[12:0];
            default: ;
        endcase
    endtask

    // Wait until every expected gain has come back and the pipeline is empty.
    task automatic drain;
        while (gain_queue.size() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES) @(posedge clk);
    endtask

    // Load a full setting, with junk in the upper bits and a write past the map.
    task automatic load_cfg(mask_cfg_t c);
        apb_write(REG_CUTOFF, {16'($urandom), c.radius});
        apb_write(REG_ORDER,  {28'($urandom), c.order});
        apb_write(REG_NOTCH,  {16'($urandom), c.width});
        apb_write(REG_MODE,   {31'($urandom), c.mode});
        apb_write(REG_ROWS,   {19'($urandom), c.rows});
        apb_write(REG_COLS,   {19'($urandom), c.cols});
        apb_write(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one coordinate beat; the expectation is recorded at acceptance.
    task automatic send_coord(logic [11:0] row, logic [11:0] col, logic known,
                              logic [15:0] gain);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {col, row};
        do
            @(posedge clk);
        while (!s_tready);
        gain_queue.push_back(mask_gain(row, col));
        literal_queue.push_back(known);
        literal_gain.push_back(gain);
    endtask

    // Lower the valid after the last beat of a burst.
    task automatic stop_sending;
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // Random setting with the extremes drawn often.
    function automatic mask_cfg_t draw_cfg();
        mask_cfg_t c;
        case ($urandom_range(0, 4))
            0: c.radius = 16'd1;
            1: c.radius = 16'hFFFF;
            2: c.radius = 16'($urandom_range(1, 64));
            3: c.radius = 16'($urandom_range(1, 2048));
            default: c.radius = 16'($urandom);
        endcase
        c.order = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
        case ($urandom_range(0, 4))
            0: c.width = 16'd0;
            1: c.width = 16'hFFFF;
            2: c.width = 16'($urandom_range(1, 1024));
            default: c.width = 16'($urandom);
        endcase
        c.mode = 1'($urandom);
        c.rows = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(1, 4096));
        c.cols = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(1, 4096));
        return c;
    endfunction

    // Random coordinate: half near the centre within a few radii, half anywhere.
    function automatic logic [11:0] draw_coord(int centre);
        int span;
        int v;
        if ($urandom_range(0, 1) == 0)
            return 12'($urandom);
        span = (int'(mask_cfg.radius) >> 3) + 4;
        v = centre + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return 12'(v);
    endfunction

    // Gain checker: compares each accepted beat with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (gain_queue.size() == 0)
            begin
                $display("%0t: unexpected gain beat, actual %0d", $realtime, m_tdata);
                err_count++;
            end
            else
            begin
                if (m_tdata !== gain_queue[0])
                begin
                    $display("%0t: gain mismatch, expected %0d, actual %0d",
                             $realtime, gain_queue[0], m_tdata);
                    err_count++;
                end
                else if (literal_queue[0] && m_tdata !== literal_gain[0])
                begin
                    $display("%0t: gain mismatch on directed point, expected %0d, actual %0d",
                             $realtime, literal_gain[0], m_tdata);
                    err_count++;
                end
                void'(gain_queue.pop_front());
                void'(literal_queue.pop_front());
                void'(literal_gain.pop_front());
            end
        end
    end

    // Receiver: random stalls per beat, plus one long hold-off on request.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_req)
            begin
                gap = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (gap > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    // Main sequence: reset, directed table, then random phases.
    initial
    begin
        int cur_sel;
        mask_cfg_t c;
        err_count   = 0;
        cycle_count = 0;
        send_idle   = 1'b1;
        recv_idle   = 1'b1;
        hold_req    = 1'b0;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        mask_cfg = '{radius: 16'd32, order: 4'd4, width: 16'd768, mode: MODE_LOWPASS,
                     rows: 13'd512, cols: 13'd512};

        // Settings for the directed table; the first is the reset state.
        cfg_sets[0] = mask_cfg;
        cfg_sets[1] = '{16'd32, 4'd4, 16'd768, MODE_BANDREJ, 13'd512, 13'd512};
        cfg_sets[2] = '{16'd32, 4'd4, 16'd0, MODE_BANDREJ, 13'd512, 13'd512};
        cfg_sets[3] = '{16'd0, 4'd4, 16'd768, MODE_LOWPASS, 13'd512, 13'd512};
        cfg_sets[4] = '{16'd32, 4'd0, 16'd768, MODE_LOWPASS, 13'd512, 13'd512};
        cfg_sets[5] = '{16'hFFFF, 4'hF, 16'hFFFF, MODE_BANDREJ, 13'd0, 13'h1FFF};

        // Directed points: centre, corners, the cutoff, the ring and the corner cases.
        probes = '{
            '{0, 12'd256, 12'd256, 1'b1, 16'd32768},
            '{0, 12'd0,   12'd0,   1'b1, 16'd0},
            '{0, 12'hFFF, 12'hFFF, 1'b1, 16'd0},
            '{0, 12'd256, 12'd258, 1'b1, 16'd16384},
            '{0, 12'd257, 12'd256, 1'b0, 16'd0},
            '{0, 12'd255, 12'd257, 1'b0, 16'd0},
            '{1, 12'd256, 12'd258, 1'b1, 16'd0},
            '{1, 12'd256, 12'd256, 1'b1, 16'd32768},
            '{1, 12'd258, 12'd258, 1'b0, 16'd0},
            '{1, 12'd250, 12'd256, 1'b0, 16'd0},
            '{2, 12'd0,   12'd0,   1'b1, 16'd32768},
            '{2, 12'd260, 12'd251, 1'b1, 16'd32768},
            '{3, 12'd256, 12'd256, 1'b1, 16'd0},
            '{3, 12'hAAA, 12'h555, 1'b1, 16'd0},
            '{4, 12'd256, 12'd256, 1'b1, 16'd16384},
            '{4, 12'd256, 12'd258, 1'b1, 16'd16384},
            '{5, 12'd0,   12'd2048, 1'b0, 16'd0},
            '{5, 12'h555, 12'hAAA, 1'b0, 16'd0},
            '{5, 12'hFFF, 12'd0,   1'b0, 16'd0},
            '{5, 12'd100, 12'd2000, 1'b0, 16'd0}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table; a change of setting waits for the pipeline to empty.
        cur_sel = 0;
        foreach (probes[i])
        begin
            if (probes[i].cfg_sel != cur_sel)
            begin
                stop_sending();
                drain();
                cur_sel = probes[i].cfg_sel;
                load_cfg(cfg_sets[cur_sel]);
            end
            send_coord(probes[i].row, probes[i].col, probes[i].known, probes[i].gain);
        end

        // Random phases; the first fills the pipeline against a long stall.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            stop_sending();
            drain();
            c = draw_cfg();
            if (ph == 1)
                c = '{16'd1, 4'd1, 16'd0, MODE_LOWPASS, 13'd1, 13'd1};
            if (ph == 2)
                c = '{16'hFFFF, 4'd8, 16'hFFFF, MODE_BANDREJ, 13'd4096, 13'd4096};
            load_cfg(c);
            send_idle = (ph == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            recv_idle = (ph == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
            if (ph == 0)
                hold_req = 1'b1;
            for (int k = 0; k < PHASE_BEATS; k++)
                send_coord(draw_coord(centre_of(mask_cfg.rows)),
                           draw_coord(centre_of(mask_cfg.cols)), 1'b0, 16'd0);
        end

        stop_sending();
        drain();
        if (gain_queue.size() != 0)
            err_count++;
        if (err_count == 0)
            $display("butterworth_mask_gain_core_tb: done, clean");
        else
            $display("butterworth_mask_gain_core_tb: done, errors");
        $finish;
    end

endmodule
